FILE: hdl/sha256bc_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 block compression package
// Shared widths, round constants, initial hash value, types and the SHA-256
// bit functions.
// ----------------------------------------------------------------------------
package sha256bc_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned IdxW       = $clog2(BlockWords);
  localparam int unsigned RndW       = $clog2(NumRounds);
  localparam int unsigned CfgIdxW    = $clog2(NumWords);
  localparam int unsigned QueueDepth = 2;

  typedef logic [WordW-1:0]                 word_t;
  typedef logic [NumWords-1:0][WordW-1:0]   hash_t;
  typedef logic [BlockWords-1:0][WordW-1:0] block_t;

  // one complete 512-bit block as handed from front to back
  typedef struct packed {
    logic   start;
    block_t words;
  } blk_t;

  typedef struct packed {
    logic full;
    logic start_pend;
  } q_stat_t;

  localparam hash_t InitReset = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WordW-1:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_s0(word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(word_t e, word_t f, word_t g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(word_t a, word_t b, word_t c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: hdl/sha256_block_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 block compression
// Usage:
//   Slave stream: one big-endian message word per transaction in tdata;
//   tuser marks the first word of a message, which reloads the chaining
//   value from the init registers (written through the cfg port).
//   Every sixteenth word completes a block; the block then runs 64 rounds,
//   one round per cycle in the round engine, and the updated 256-bit hash
//   appears as one master transaction.
//   Sustained throughput is set by the single round unit; up to two
//   complete blocks wait in the queue while words keep streaming in.
//   A start word is held off while a queued block from an earlier start has
//   not entered the round engine yet.
//   Reset loads the standard initial hash into the init registers and the
//   chaining value and empties the queue.
//   If the master side stalls, the result is held and the engine stops at
//   the end of the next block; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module sha256_block_compress #(
  parameter int unsigned QueueDepth = sha256bc_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sha256bc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [31:0]                       s_axis_tdata_i,  // message_word
  input  logic                              s_axis_tuser_i,  // start_message
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // hash_a, hash_b, hash_c, hash_d, hash_e, hash_f, hash_g, hash_h
  output logic [255:0]                      m_axis_tdata_o
);

  sha256bc_pkg::q_stat_t q_stat;
  sha256bc_pkg::blk_t    push_blk, q_blk;
  sha256bc_pkg::hash_t   snap, hash;
  logic                  q_push, q_pop, q_valid;

  sha256bc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_word_i   (s_axis_tdata_i),
    .in_start_i  (s_axis_tuser_i),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_blk_o  (push_blk),
    .snap_o      (snap)
  );

  sha256bc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .blk_i   (push_blk),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .blk_o   (q_blk),
    .stat_o  (q_stat)
  );

  sha256bc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_blk_i     (q_blk),
    .q_pop_o     (q_pop),
    .snap_i      (snap),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hash_o      (hash)
  );

  assign m_axis_tdata_o = hash;

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("block pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("block popped from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |-> !q_stat.start_pend)
    else $error("start accepted while init snapshot still needed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_blk.start) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("chaining value reloaded under a pending result");

endmodule

FILE: hdl/sha256bc_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Holds the init registers, takes message words, assembles 16-word blocks and
// pushes them into the block queue. Snapshots the init value on start.
// ----------------------------------------------------------------------------
module sha256bc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sha256bc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  sha256bc_pkg::word_t          cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sha256bc_pkg::word_t          in_word_i,
  input  logic                         in_start_i,
  input  sha256bc_pkg::q_stat_t        q_stat_i,
  output logic                         push_o,
  output sha256bc_pkg::blk_t           push_blk_o,
  output sha256bc_pkg::hash_t          snap_o
);

  localparam logic [sha256bc_pkg::IdxW-1:0] LastIdx =
    sha256bc_pkg::IdxW'(sha256bc_pkg::BlockWords - 1);

  sha256bc_pkg::hash_t                            init_q, init_d;
  sha256bc_pkg::hash_t                            snap_q, snap_d;
  logic [sha256bc_pkg::BlockWords-2:0][sha256bc_pkg::WordW-1:0] buf_q, buf_d;
  logic [sha256bc_pkg::IdxW-1:0]                  idx_q, idx_d, eff_idx;
  logic                                           bstart_q, bstart_d;
  logic                                           accept;

  assign eff_idx    = in_start_i ? '0 : idx_q;
  assign in_ready_o = in_start_i ? !q_stat_i.start_pend
                                 : !((idx_q == LastIdx) && q_stat_i.full);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (eff_idx == LastIdx);
  assign snap_o     = snap_q;

  always_comb begin
    push_blk_o.start = bstart_q;
    for (int i = 0; i < sha256bc_pkg::BlockWords - 1; i++) begin
      push_blk_o.words[i] = buf_q[i];
    end
    push_blk_o.words[sha256bc_pkg::BlockWords-1] = in_word_i;
  end

  always_comb begin
    init_d   = init_q;
    snap_d   = snap_q;
    buf_d    = buf_q;
    idx_d    = idx_q;
    bstart_d = bstart_q;
    if (cfg_we_i) begin
      init_d[cfg_idx_i] = cfg_wdata_i;
    end
    if (accept) begin
      if (in_start_i) begin
        snap_d   = init_q;
        bstart_d = 1'b1;
      end
      if (eff_idx == LastIdx) begin
        idx_d    = '0;
        bstart_d = 1'b0;
      end else begin
        buf_d[eff_idx] = in_word_i;
        idx_d          = eff_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= sha256bc_pkg::InitReset;
      snap_q   <= sha256bc_pkg::InitReset;
      idx_q    <= '0;
      bstart_q <= 1'b0;
    end else begin
      init_q   <= init_d;
      snap_q   <= snap_d;
      idx_q    <= idx_d;
      bstart_q <= bstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

FILE: hdl/sha256bc_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of complete message blocks between front end and round engine.
// ----------------------------------------------------------------------------
module sha256bc_queue #(
  parameter int unsigned Depth = sha256bc_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sha256bc_pkg::blk_t      blk_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output sha256bc_pkg::blk_t      blk_o,
  output sha256bc_pkg::q_stat_t   stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sha256bc_pkg::blk_t ent_q [Depth];
  logic [Depth-1:0]   vld_q, vld_d;
  logic [Depth-1:0]   st_q;
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic               do_push, do_pop;

  assign valid_o           = vld_q[rd_q];
  assign blk_o             = ent_q[rd_q];
  assign stat_o.full       = vld_q[wr_q];
  assign stat_o.start_pend = |(vld_q & st_q);
  assign do_push           = push_i && !vld_q[wr_q];
  assign do_pop            = pop_i && vld_q[rd_q];

  always_comb begin
    vld_d = vld_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_pop) begin
      vld_d[rd_q] = 1'b0;
      rd_d        = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push) begin
      vld_d[wr_q] = 1'b1;
      wr_d        = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      st_q  <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      vld_q <= vld_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      if (do_push) begin
        st_q[wr_q] <= blk_i.start;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= blk_i;
    end
  end

endmodule

FILE: hdl/sha256bc_back.sv
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Pops one block, runs 64 rounds at one round per cycle with a rolling
// 16-word schedule window, then folds the result into the chaining value.
// ----------------------------------------------------------------------------
module sha256bc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sha256bc_pkg::blk_t    q_blk_i,
  output logic                  q_pop_o,
  input  sha256bc_pkg::hash_t   snap_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256bc_pkg::hash_t   hash_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRound = 3'b010,
    StFinal = 3'b100
  } bk_state_e;

  localparam logic [sha256bc_pkg::RndW-1:0] LastRnd =
    sha256bc_pkg::RndW'(sha256bc_pkg::NumRounds - 1);

  bk_state_e                      st_q, st_d;
  logic [sha256bc_pkg::RndW-1:0]  cnt_q, cnt_d;
  logic                           ov_q, ov_d;
  sha256bc_pkg::hash_t            chain_q, chain_d;
  sha256bc_pkg::hash_t            wv_q, wv_d, wv_rnd;
  sha256bc_pkg::block_t           w_q, w_d;
  sha256bc_pkg::word_t            t1, t2, w_new;
  logic                           slot_free;

  assign slot_free   = !ov_q || out_ready_i;
  assign q_pop_o     = (st_q == StIdle) && q_valid_i && (!q_blk_i.start || slot_free);
  assign out_valid_o = ov_q;
  assign hash_o      = chain_q;

  always_comb begin
    t1 = wv_q[7] + sha256bc_pkg::big_s1(wv_q[4])
       + sha256bc_pkg::ch(wv_q[4], wv_q[5], wv_q[6])
       + sha256bc_pkg::RoundK[cnt_q] + w_q[0];
    t2 = sha256bc_pkg::big_s0(wv_q[0]) + sha256bc_pkg::maj(wv_q[0], wv_q[1], wv_q[2]);
    wv_rnd[0] = t1 + t2;
    wv_rnd[1] = wv_q[0];
    wv_rnd[2] = wv_q[1];
    wv_rnd[3] = wv_q[2];
    wv_rnd[4] = wv_q[3] + t1;
    wv_rnd[5] = wv_q[4];
    wv_rnd[6] = wv_q[5];
    wv_rnd[7] = wv_q[6];
    w_new = w_q[0] + sha256bc_pkg::small_s0(w_q[1]) + w_q[9]
          + sha256bc_pkg::small_s1(w_q[14]);
  end

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    chain_d = chain_q;
    wv_d    = wv_q;
    w_d     = w_q;
    ov_d    = ov_q && !out_ready_i;
    case (st_q)
      StIdle: begin
        if (q_pop_o) begin
          w_d   = q_blk_i.words;
          cnt_d = '0;
          st_d  = StRound;
          if (q_blk_i.start) begin
            chain_d = snap_i;
            wv_d    = snap_i;
          end else begin
            wv_d = chain_q;
          end
        end
      end
      StRound: begin
        wv_d  = wv_rnd;
        w_d   = {w_new, w_q[sha256bc_pkg::BlockWords-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastRnd) begin
          st_d = StFinal;
        end
      end
      StFinal: begin
        if (slot_free) begin
          for (int i = 0; i < sha256bc_pkg::NumWords; i++) begin
            chain_d[i] = chain_q[i] + wv_q[i];
          end
          ov_d = 1'b1;
          st_d = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      chain_q <= sha256bc_pkg::InitReset;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
    w_q  <= w_d;
  end

endmodule
